/* rtl/core/byte_register_vm_execute_unit_macros.svh */
// Assertion helper macros used by the checker file.
`ifndef BYTE_REGISTER_VM_EXECUTE_UNIT_MACROS_SVH
`define BYTE_REGISTER_VM_EXECUTE_UNIT_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define BRV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define BRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/brvm_pkg.sv */
package brvm_pkg;

  localparam int unsigned AddrW     = 12;
  localparam int unsigned InstrW    = 16;
  localparam int unsigned RegW      = 8;
  localparam int unsigned NumRegs   = 16;
  localparam int unsigned RegIdxW   = 4;
  localparam int unsigned StackDepthDefault = 16;
  localparam logic [AddrW-1:0] ResetStart = 12'h200;
  localparam logic [RegIdxW-1:0] FlagReg  = 4'hF;
  localparam logic [InstrW-1:0] InstrRet  = 16'h00EE;

  // Operation classes chosen by the front end
  typedef enum logic [3:0] {
    OP_NOP, OP_RET, OP_JMP, OP_CALL, OP_SEQI, OP_SNEI, OP_SEQR, OP_SNER,
    OP_LDI, OP_ADDI, OP_ALU, OP_LDIDX, OP_JMPV0
  } op_e;

  // ALU sub-operations of the 8xy group
  typedef enum logic [3:0] {
    ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3,
    ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7,
    ALU_SHL = 4'hE
  } alu_e;

  typedef struct packed {
    op_e                op;
    alu_e               alu;
    logic [RegIdxW-1:0] x;
    logic [RegIdxW-1:0] y;
    logic [RegW-1:0]    kk;
    logic [AddrW-1:0]   nnn;
    logic               unh;
  } uop_t;

  typedef struct packed {
    logic [AddrW-1:0]   next_address;
    logic [AddrW-1:0]   index_value;
    logic [RegIdxW-1:0] dest_register;
    logic [RegW-1:0]    dest_value;
    logic               dest_written;
    logic               flag_value;
    logic               stack_fault;
    logic               not_handled;
  } result_t;

endpackage

/* rtl/core/byte_register_vm_execute_unit.sv */
// Channel     | Handshake               | Payload
// instruction | instruction_valid/stall | instruction_i
// result      | result_valid/stall      | next_address_o .. not_handled_o
// config      | cfg_valid/ready         | cfg_data_i (pc load)
// One instruction per cycle while results are not stalled; each accepted
// instruction goes through a queue slot, then the execute register (result).
// Execution of each instruction finishes in the single execute stage.
// Reset loads pc with 0x200, clears registers, index and stack level.
// A result stall holds the execute register; the two-entry queue then fills.
module byte_register_vm_execute_unit import brvm_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [AddrW-1:0]  cfg_data_i,
  input  logic              instruction_valid_i,
  output logic              instruction_stall_o,
  input  logic [InstrW-1:0] instruction_i,
  output logic              result_valid_o,
  input  logic              result_stall_i,
  output logic [AddrW-1:0]  next_address_o,
  output logic [AddrW-1:0]  index_value_o,
  output logic [RegIdxW-1:0] dest_register_o,
  output logic [RegW-1:0]   dest_value_o,
  output logic              dest_written_o,
  output logic              flag_value_o,
  output logic              stack_fault_o,
  output logic              not_handled_o
);

  uop_t    dec_uop, q_uop;
  logic    q_valid, q_stall;
  result_t res;

  assign cfg_ready_o = 1'b1;

  brvm_decode u_decode (
    .instr_i (instruction_i),
    .uop_o   (dec_uop)
  );

  brvm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (instruction_valid_i),
    .in_stall_o  (instruction_stall_o),
    .in_data_i   (dec_uop),
    .out_valid_o (q_valid),
    .out_stall_i (q_stall),
    .out_data_o  (q_uop)
  );

  brvm_execute #(.StackDepth(StackDepth)) u_execute (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .uop_valid_i (q_valid),
    .uop_stall_o (q_stall),
    .uop_i       (q_uop),
    .res_valid_o (result_valid_o),
    .res_stall_i (result_stall_i),
    .res_o       (res)
  );

  assign next_address_o  = res.next_address;
  assign index_value_o   = res.index_value;
  assign dest_register_o = res.dest_register;
  assign dest_value_o    = res.dest_value;
  assign dest_written_o  = res.dest_written;
  assign flag_value_o    = res.flag_value;
  assign stack_fault_o   = res.stack_fault;
  assign not_handled_o   = res.not_handled;

endmodule

/* rtl/core/brvm_decode.sv */
module brvm_decode import brvm_pkg::*; (
  input  logic [InstrW-1:0] instr_i,
  output uop_t              uop_o
);

  // Classify the instruction word
  always_comb begin
    uop_o     = '0;
    uop_o.x   = instr_i[11:8];
    uop_o.y   = instr_i[7:4];
    uop_o.kk  = instr_i[7:0];
    uop_o.nnn = instr_i[11:0];
    uop_o.op  = OP_NOP;
    uop_o.alu = ALU_MOV;
    unique case (instr_i[15:12])
      4'h0: begin
        if (instr_i == InstrRet) uop_o.op = OP_RET;
        else uop_o.unh = 1'b1;
      end
      4'h1: uop_o.op = OP_JMP;
      4'h2: uop_o.op = OP_CALL;
      4'h3: uop_o.op = OP_SEQI;
      4'h4: uop_o.op = OP_SNEI;
      4'h5: uop_o.op = OP_SEQR;
      4'h6: uop_o.op = OP_LDI;
      4'h7: uop_o.op = OP_ADDI;
      4'h8: begin
        case (instr_i[3:0]) inside
          4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
            uop_o.op  = OP_ALU;
            uop_o.alu = alu_e'(instr_i[3:0]);
          end
          default: uop_o.unh = 1'b1;
        endcase
      end
      4'h9: uop_o.op = OP_SNER;
      4'hA: uop_o.op = OP_LDIDX;
      4'hB: uop_o.op = OP_JMPV0;
      default: uop_o.unh = 1'b1;
    endcase
  end

endmodule

/* rtl/core/brvm_queue.sv */
module brvm_queue import brvm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  uop_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output uop_t out_data_o
);

  // Two-entry queue: main slot plus skid slot
  uop_t main_q, skid_q;
  logic main_v_q, skid_v_q;

  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;
  assign in_stall_o  = skid_v_q;

  logic pop, push;
  assign pop  = main_v_q && !out_stall_i;
  assign push = in_valid_i && !skid_v_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (pop) skid_v_q <= 1'b0;
      end else if (push && main_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end
      if (pop) main_v_q <= skid_v_q || push;
      else if (push) main_v_q <= 1'b1;
    end
  end

  // Move payload
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) main_q <= skid_q;
    end else if (push) begin
      if (!main_v_q || pop) main_q <= in_data_i;
      else skid_q <= in_data_i;
    end
  end

endmodule

/* rtl/core/brvm_execute.sv */
module brvm_execute import brvm_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_data_i,
  input  logic             uop_valid_i,
  output logic             uop_stall_o,
  input  uop_t             uop_i,
  output logic             res_valid_o,
  input  logic             res_stall_i,
  output result_t          res_o
);

  localparam int unsigned SpW  = $clog2(StackDepth);
  localparam int unsigned LvlW = $clog2(StackDepth + 1);
  localparam logic [LvlW-1:0] DepthC = LvlW'(StackDepth);

  logic [AddrW-1:0] pc_q, idx_q;
  logic [RegW-1:0]  regs_q [NumRegs];
  logic [LvlW-1:0]  lvl_q;
  logic [AddrW-1:0] stack_q [StackDepth];
  logic             res_v_q;
  result_t          res_q;

  logic fire;
  assign uop_stall_o = res_v_q && res_stall_i;
  assign fire        = uop_valid_i && !uop_stall_o;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  logic [RegW-1:0]  vx, vy, val;
  logic [AddrW-1:0] pc2, pc4, nxt, ret_addr;
  logic             wr, setf, flag, fault, push, pop;
  logic [RegW:0]    sum;
  logic [SpW-1:0]   rd_ptr;

  assign rd_ptr   = SpW'(lvl_q - LvlW'(1));
  assign ret_addr = stack_q[rd_ptr];

  // Execute one operation
  always_comb begin
    vx   = regs_q[uop_i.x];
    vy   = regs_q[uop_i.y];
    pc2  = pc_q + AddrW'(2);
    pc4  = pc_q + AddrW'(4);
    nxt  = pc2;
    wr   = 1'b0;
    setf = 1'b0;
    flag = 1'b0;
    val  = '0;
    fault = 1'b0;
    push = 1'b0;
    pop  = 1'b0;
    sum  = '0;
    unique case (uop_i.op)
      OP_RET: begin
        if (lvl_q == '0) fault = 1'b1;
        else begin
          pop = 1'b1;
          nxt = ret_addr;
        end
      end
      OP_JMP: nxt = uop_i.nnn;
      OP_CALL: begin
        if (lvl_q >= DepthC) fault = 1'b1;
        else begin
          push = 1'b1;
          nxt  = uop_i.nnn;
        end
      end
      OP_SEQI: if (vx == uop_i.kk) nxt = pc4;
      OP_SNEI: if (vx != uop_i.kk) nxt = pc4;
      OP_SEQR: if (vx == vy) nxt = pc4;
      OP_SNER: if (vx != vy) nxt = pc4;
      OP_LDI: begin
        wr  = 1'b1;
        val = uop_i.kk;
      end
      OP_ADDI: begin
        wr  = 1'b1;
        val = vx + uop_i.kk;
      end
      OP_ALU: begin
        wr = 1'b1;
        unique case (uop_i.alu)
          ALU_MOV: val = vy;
          ALU_OR:  val = vx | vy;
          ALU_AND: val = vx & vy;
          ALU_XOR: val = vx ^ vy;
          ALU_ADD: begin
            sum  = {1'b0, vx} + {1'b0, vy};
            val  = sum[RegW-1:0];
            setf = 1'b1;
            flag = sum[RegW];
          end
          ALU_SUB: begin
            val = vx - vy; setf = 1'b1; flag = vx > vy;
          end
          ALU_SHR: begin
            val = vx >> 1; setf = 1'b1; flag = vx[0];
          end
          ALU_SUBN: begin
            val = vy - vx; setf = 1'b1; flag = vy > vx;
          end
          ALU_SHL: begin
            val = vx << 1; setf = 1'b1; flag = vx[RegW-1];
          end
          default: val = vy;
        endcase
      end
      OP_JMPV0: nxt = uop_i.nnn + AddrW'(regs_q[0]);
      default: nxt = pc2;
    endcase
  end

  // Update architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= ResetStart;
      idx_q <= '0;
      lvl_q <= '0;
      res_v_q <= 1'b0;
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_data_i;
      if (res_v_q && !res_stall_i) res_v_q <= 1'b0;
      if (fire) begin
        res_v_q <= 1'b1;
        pc_q <= nxt;
        if (uop_i.op == OP_LDIDX) idx_q <= uop_i.nnn;
        if (push) lvl_q <= lvl_q + LvlW'(1);
        if (pop)  lvl_q <= lvl_q - LvlW'(1);
        if (setf) regs_q[FlagReg] <= {{(RegW-1){1'b0}}, flag};
        if (wr)   regs_q[uop_i.x] <= val;
      end
    end
  end

  // Write the return stack
  always_ff @(posedge clk_i) begin
    if (fire && push) stack_q[lvl_q[SpW-1:0]] <= pc2;
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q.next_address  <= nxt;
      res_q.index_value   <= (uop_i.op == OP_LDIDX) ? uop_i.nnn : idx_q;
      res_q.dest_register <= wr ? uop_i.x : '0;
      res_q.dest_value    <= wr ? val : '0;
      res_q.dest_written  <= wr;
      res_q.flag_value    <= (wr && uop_i.x == FlagReg) ? val[0] :
                             (setf ? flag : regs_q[FlagReg][0]);
      res_q.stack_fault   <= fault;
      res_q.not_handled   <= uop_i.unh;
    end
  end

endmodule

/* rtl/core/brvm_checker.sv */
`include "byte_register_vm_execute_unit_macros.svh"

module brvm_checker import brvm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              instruction_stall_o,
  input logic              result_valid_o,
  input logic              result_stall_i,
  input logic [AddrW-1:0]  next_address_o,
  input logic [RegIdxW-1:0] dest_register_o,
  input logic [RegW-1:0]   dest_value_o,
  input logic              dest_written_o,
  input logic              stack_fault_o,
  input logic              not_handled_o
);

  `BRV_ASSERT_IMP(a_no_dest_unwritten, clk_i, rst_ni,
    result_valid_o && !dest_written_o,
    dest_register_o == '0 && dest_value_o == '0, "dest fields set without write")
  `BRV_ASSERT_IMP(a_unh_no_write, clk_i, rst_ni, result_valid_o && not_handled_o,
    !dest_written_o && !stack_fault_o, "unhandled word had side effects")
  `BRV_ASSERT_IMP(a_stall_needs_backpressure, clk_i, rst_ni, instruction_stall_o,
    result_valid_o, "input stalled with no pending result")
  `BRV_ASSERT_NEXT(a_result_held, clk_i, rst_ni, result_valid_o && result_stall_i,
    result_valid_o && $stable(next_address_o) && $stable(dest_value_o)
    && $stable(dest_register_o), "stalled result changed")

endmodule

bind byte_register_vm_execute_unit brvm_checker u_brvm_checker (.*);
